>>> design/vertex_dedup_indexer_assert.svh
// Assertion macros used by the vdi_checker file.
`ifndef VERTEX_DEDUP_INDEXER_ASSERT_SVH
`define VERTEX_DEDUP_INDEXER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define VDI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define VDI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/vdi_pkg.sv
package vdi_pkg;

   localparam int MAX_UNIQUE  = 1024;
   localparam int MAX_WORDS   = 8;
   localparam int IN_WORDS    = 8;
   localparam int STORE_WORDS = (MAX_WORDS < IN_WORDS) ? MAX_WORDS : IN_WORDS;

   localparam int ADDR_W  = $clog2(MAX_UNIQUE);
   localparam int COUNT_W = ADDR_W + 1;
   localparam int WORD_W  = 32;
   localparam int IDX_W   = 10;
   localparam int CFG_W   = 4;

   localparam logic [CFG_W-1:0] WORDS_RESET = 4'd8;

   typedef logic [WORD_W-1:0] word_type;

   // Token that walks down the cell row: one stored entry under test.
   typedef struct packed {
      logic              valid;
      logic              last;
      logic              eq;
      logic [ADDR_W-1:0] addr;
   } tok_type;

   // Append write, broadcast to every cell.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } wr_type;

endpackage

>>> design/vdi_ram.sv
module vdi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/vdi_cell.sv
module vdi_cell (
   input  logic             clock,
   input  logic             reset,
   input  vdi_pkg::tok_type tok_i,
   output vdi_pkg::tok_type tok_o,
   input  logic             active,
   input  vdi_pkg::word_type word,
   input  vdi_pkg::wr_type  wr
);

   vdi_pkg::tok_type  tok_a_ff;
   vdi_pkg::tok_type  tok_b_ff;
   vdi_pkg::tok_type  tok_b_in;
   vdi_pkg::word_type stored;

   function automatic logic is_nan(input vdi_pkg::word_type x);
      return x[30:0] > 31'h7F80_0000;
   endfunction

   // IEEE single equality: signed zeros match, NaN never matches.
   function automatic logic float_eq(input vdi_pkg::word_type a,
                                     input vdi_pkg::word_type b);
      logic zeros;
      zeros = ((a[30:0] | b[30:0]) == 31'd0);
      return !is_nan(a) && !is_nan(b) && (zeros || (a == b));
   endfunction

   // This cell's column of the unique table.
   vdi_ram #(
      .WIDTH (vdi_pkg::WORD_W),
      .DEPTH (vdi_pkg::MAX_UNIQUE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (word),
      .rd_addr (tok_i.addr),
      .rd_data (stored)
   );

   always_comb begin
      tok_b_in = tok_a_ff;
      tok_b_in.eq = tok_a_ff.eq && (!active || float_eq(word, stored));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_a_ff <= '0;
         tok_b_ff <= '0;
      end else begin
         tok_a_ff <= tok_i;
         tok_b_ff <= tok_b_in;
      end
   end

   assign tok_o = tok_b_ff;

endmodule

>>> design/vertex_dedup_indexer.sv
// Results: for a hit on entry i, rsp_valid rises once entry i's token reaches the row's tail;
// a miss reports once the last stored entry reaches the tail, or straight from search on an empty table.
// Throughput: one stored entry compared per cycle through the 8-cell row;
// after a hit on any entry but the last, the row drains before busy drops.
// Reset: synchronous; table empties (count 0), vertex_words returns to 8, no clearing pass.
// Results are strobed on rsp_valid for one cycle; the receiver cannot stall.
module vertex_dedup_indexer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_first_of_mesh,
   input  logic [31:0]                req_comp0,
   input  logic [31:0]                req_comp1,
   input  logic [31:0]                req_comp2,
   input  logic [31:0]                req_comp3,
   input  logic [31:0]                req_comp4,
   input  logic [31:0]                req_comp5,
   input  logic [31:0]                req_comp6,
   input  logic [31:0]                req_comp7,
   output logic                       rsp_valid,
   output logic [vdi_pkg::IDX_W-1:0]  rsp_vertex_index,
   output logic                       rsp_is_new,
   output logic                       rsp_table_full,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [vdi_pkg::CFG_W-1:0]  csr_vertex_words
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [vdi_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [vdi_pkg::COUNT_W-1:0]       issue_ff, issue_in;
   logic [vdi_pkg::COUNT_W-1:0]       issue_last;
   logic [vdi_pkg::CFG_W-1:0]         words_ff;
   vdi_pkg::word_type                 comp_ff [vdi_pkg::IN_WORDS];
   vdi_pkg::word_type                 req_comp [vdi_pkg::IN_WORDS];
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [vdi_pkg::IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic                              rsp_new_ff, rsp_new_in;
   logic                              rsp_full_ff, rsp_full_in;
   logic [vdi_pkg::STORE_WORDS-1:0]   active;
   vdi_pkg::tok_type                  chain [vdi_pkg::STORE_WORDS+1];
   vdi_pkg::tok_type                  tail;
   vdi_pkg::wr_type                   wr;
   logic                              accept;

   assign req_comp[0] = req_comp0;
   assign req_comp[1] = req_comp1;
   assign req_comp[2] = req_comp2;
   assign req_comp[3] = req_comp3;
   assign req_comp[4] = req_comp4;
   assign req_comp[5] = req_comp5;
   assign req_comp[6] = req_comp6;
   assign req_comp[7] = req_comp7;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   // Address of the last entry issued into the row.
   assign issue_last = issue_ff - 1'b1;

   // Word 0 always compares; a count past the row saturates to all cells.
   always_comb begin
      for (int k = 0; k < vdi_pkg::STORE_WORDS; k++) begin
         active[k] = (k == 0) || (int'(words_ff) > k);
      end
   end

   // Feed one entry per cycle into the head of the row.
   always_comb begin
      chain[0].valid = (state_ff == ST_SEARCH) && (issue_ff < count_ff);
      chain[0].last  = ((issue_ff + 1'b1) == count_ff);
      chain[0].eq    = 1'b1;
      chain[0].addr  = issue_ff[vdi_pkg::ADDR_W-1:0];
   end

   for (genvar k = 0; k < vdi_pkg::STORE_WORDS; k++) begin : g_cell
      vdi_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_i  (chain[k]),
         .tok_o  (chain[k+1]),
         .active (active[k]),
         .word   (comp_ff[k]),
         .wr     (wr)
      );
   end

   assign tail = chain[vdi_pkg::STORE_WORDS];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      wr.en        = 1'b0;
      wr.addr      = count_ff[vdi_pkg::ADDR_W-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SEARCH;
               issue_in = '0;
               if (req_first_of_mesh) begin
                  count_in = '0;
               end
            end
         end
         ST_SEARCH: begin
            if (chain[0].valid) begin
               issue_in = issue_ff + 1'b1;
            end
            priority if (tail.valid && tail.eq) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = vdi_pkg::IDX_W'(tail.addr);
               rsp_new_in   = 1'b0;
               rsp_full_in  = 1'b0;
               state_in     = tail.last ? ST_IDLE : ST_DRAIN;
            end else if ((count_ff == '0) || (tail.valid && tail.last)) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (count_ff == vdi_pkg::COUNT_W'(vdi_pkg::MAX_UNIQUE)) begin
                  rsp_index_in = '0;
                  rsp_new_in   = 1'b0;
                  rsp_full_in  = 1'b1;
               end else begin
                  wr.en        = 1'b1;
                  count_in     = count_ff + 1'b1;
                  rsp_index_in = vdi_pkg::IDX_W'(count_ff);
                  rsp_new_in   = 1'b1;
                  rsp_full_in  = 1'b0;
               end
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_DRAIN: begin
            // Drop entries still in the row behind the hit.
            if (tail.valid && (tail.addr == issue_last[vdi_pkg::ADDR_W-1:0])) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         words_ff     <= vdi_pkg::WORDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            words_ff <= csr_vertex_words;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
      if (accept) begin
         comp_ff <= req_comp;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_table_full   = rsp_full_ff;

endmodule

>>> design/vdi_checker.sv
`include "vertex_dedup_indexer_assert.svh"

module vdi_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [vdi_pkg::IDX_W-1:0]  rsp_vertex_index,
   input logic                       rsp_is_new,
   input logic                       rsp_table_full,
   input logic                       csr_valid,
   input logic                       csr_ready
);

   `VDI_ASSERT_NOW(a_new_not_full, rsp_valid, !(rsp_is_new && rsp_table_full), "item both new and full")
   `VDI_ASSERT_NOW(a_full_index_zero, rsp_valid && rsp_table_full, rsp_vertex_index == '0, "full item with nonzero index")
   `VDI_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted item did not raise busy")
   `VDI_ASSERT_NEXT(a_one_rsp, rsp_valid, !rsp_valid, "two results in back-to-back cycles")
   `VDI_ASSERT_NOW(a_csr_idle, csr_valid && csr_ready, !busy, "register write taken while busy")

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_vertex_index (rsp_vertex_index),
   .rsp_is_new       (rsp_is_new),
   .rsp_table_full   (rsp_table_full),
   .csr_valid        (csr_valid),
   .csr_ready        (csr_ready)
);

>>> dv/vdi_lookup_checker.sv
`timescale 1ns / 100ps

module vdi_lookup_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_first_of_mesh,
   input  logic [31:0]                req_comp0,
   input  logic [31:0]                req_comp1,
   input  logic [31:0]                req_comp2,
   input  logic [31:0]                req_comp3,
   input  logic [31:0]                req_comp4,
   input  logic [31:0]                req_comp5,
   input  logic [31:0]                req_comp6,
   input  logic [31:0]                req_comp7,
   input  logic                       rsp_valid,
   input  logic [vdi_pkg::IDX_W-1:0]  rsp_vertex_index,
   input  logic                       rsp_is_new,
   input  logic                       rsp_table_full,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [vdi_pkg::CFG_W-1:0]  csr_vertex_words,
   output int                         mismatches,
   output int                         pending
);

   typedef logic [vdi_pkg::IN_WORDS-1:0][31:0] vertex_type;

   typedef struct packed {
      logic [vdi_pkg::IDX_W-1:0] vertex_index;
      logic                      is_new;
      logic                      table_full;
   } lookup_type;

   lookup_type                  due_lookups[$];
   vertex_type                  stored_rows [vdi_pkg::MAX_UNIQUE];
   int                          row_count;
   logic [vdi_pkg::CFG_W-1:0]   words_cfg;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   // NaN never matches; the two zeros match each other.
   function automatic bit ieee_equal(input logic [31:0] a, input logic [31:0] b);
      if (a[30:0] > 31'h7F80_0000 || b[30:0] > 31'h7F80_0000)
         return 1'b0;
      if ((a[30:0] | b[30:0]) == 31'h0)
         return 1'b1;
      return a == b;
   endfunction

   function automatic lookup_type resolve_vertex(input logic fom, input vertex_type v);
      lookup_type r;
      int         n;
      int         e;
      int         f;
      bit         same;
      n = (words_cfg == 0) ? 1 :
          ((words_cfg > vdi_pkg::STORE_WORDS) ? vdi_pkg::STORE_WORDS : int'(words_cfg));
      if (fom)
         row_count = 0;
      for (e = 0; e < row_count; e++) begin
         same = 1'b1;
         for (f = 0; f < n; f++)
            if (!ieee_equal(v[f], stored_rows[e][f]))
               same = 1'b0;
         if (same) begin
            r.vertex_index = e[vdi_pkg::IDX_W-1:0];
            r.is_new       = 1'b0;
            r.table_full   = 1'b0;
            return r;
         end
      end
      if (row_count >= vdi_pkg::MAX_UNIQUE) begin
         r.vertex_index = '0;
         r.is_new       = 1'b0;
         r.table_full   = 1'b1;
         return r;
      end
      // store every word, so a later narrower compare sees what was written
      stored_rows[row_count] = v;
      r.vertex_index = row_count[vdi_pkg::IDX_W-1:0];
      r.is_new       = 1'b1;
      r.table_full   = 1'b0;
      row_count++;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      lookup_type want;
      if (reset) begin
         row_count = 0;
         words_cfg = vdi_pkg::WORDS_RESET;
         due_lookups.delete();
      end else begin
         if (rsp_valid) begin
            if (due_lookups.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item: index %0d is_new %0b table_full %0b",
                        $time, rsp_vertex_index, rsp_is_new, rsp_table_full);
            end else begin
               want = due_lookups.pop_front();
               if (rsp_vertex_index !== want.vertex_index) begin
                  mismatches++;
                  $display("%0t: vertex_index expected %0d, actual %0d",
                           $time, want.vertex_index, rsp_vertex_index);
               end
               if (rsp_is_new !== want.is_new) begin
                  mismatches++;
                  $display("%0t: is_new expected %0b, actual %0b",
                           $time, want.is_new, rsp_is_new);
               end
               if (rsp_table_full !== want.table_full) begin
                  mismatches++;
                  $display("%0t: table_full expected %0b, actual %0b",
                           $time, want.table_full, rsp_table_full);
               end
            end
         end
         if (csr_valid && csr_ready)
            words_cfg = csr_vertex_words;
         if (start && !busy) begin
            want = resolve_vertex(req_first_of_mesh,
               {req_comp7, req_comp6, req_comp5, req_comp4,
                req_comp3, req_comp2, req_comp1, req_comp0});
            due_lookups = {due_lookups, want};
         end
      end
      pending = due_lookups.size();
   end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

   typedef logic [vdi_pkg::IN_WORDS-1:0][31:0] vertex_type;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_first_of_mesh;
   logic [31:0]                req_comp0;
   logic [31:0]                req_comp1;
   logic [31:0]                req_comp2;
   logic [31:0]                req_comp3;
   logic [31:0]                req_comp4;
   logic [31:0]                req_comp5;
   logic [31:0]                req_comp6;
   logic [31:0]                req_comp7;
   logic                       rsp_valid;
   logic [vdi_pkg::IDX_W-1:0]  rsp_vertex_index;
   logic                       rsp_is_new;
   logic                       rsp_table_full;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [vdi_pkg::CFG_W-1:0]  csr_vertex_words;
   int                         mismatches;
   int                         pending;

   bit                         no_idle;
   int                         cur_words;
   vertex_type                 mesh_history[$];

   vertex_dedup_indexer dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_of_mesh(req_first_of_mesh),
      .req_comp0        (req_comp0),
      .req_comp1        (req_comp1),
      .req_comp2        (req_comp2),
      .req_comp3        (req_comp3),
      .req_comp4        (req_comp4),
      .req_comp5        (req_comp5),
      .req_comp6        (req_comp6),
      .req_comp7        (req_comp7),
      .rsp_valid        (rsp_valid),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_words (csr_vertex_words)
   );

   vdi_lookup_checker lookup_chk (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_of_mesh(req_first_of_mesh),
      .req_comp0        (req_comp0),
      .req_comp1        (req_comp1),
      .req_comp2        (req_comp2),
      .req_comp3        (req_comp3),
      .req_comp4        (req_comp4),
      .req_comp5        (req_comp5),
      .req_comp6        (req_comp6),
      .req_comp7        (req_comp7),
      .rsp_valid        (rsp_valid),
      .rsp_vertex_index (rsp_vertex_index),
      .rsp_is_new       (rsp_is_new),
      .rsp_table_full   (rsp_table_full),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vertex_words (csr_vertex_words),
      .mismatches       (mismatches),
      .pending          (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #40_000_000;
      $display("testbench NOT OK");
      $finish;
   end

   // Leave start high after acceptance so a zero gap keeps it asserted.
   task automatic send_vertex(input logic fom, input vertex_type v);
      int gap;
      if ($urandom_range(0, 29) == 0)
         no_idle = !no_idle;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_first_of_mesh = fom;
      {req_comp7, req_comp6, req_comp5, req_comp4,
       req_comp3, req_comp2, req_comp1, req_comp0} = v;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Hold until the last item is out and the search row has drained.
   task automatic drain();
      start = 1'b0;
      while (pending != 0 || busy)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_words(input logic [vdi_pkg::CFG_W-1:0] value);
      repeat ($urandom_range(0, 13)) @(negedge clock);
      csr_valid        = 1'b1;
      csr_vertex_words = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      cur_words = (value == 0) ? 1 : ((value > 8) ? 8 : int'(value));
   endtask

   function automatic logic [31:0] pick_word();
      logic sign;
      sign = $urandom_range(0, 1);
      case ($urandom_range(0, 11))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         2:       return {sign, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
         3:       return {sign, 8'hFF, 23'h0};
         4:       return {1'b0, 8'd127 + 8'($urandom_range(0, 3)), 23'h0};
         5:       return {sign, 8'h00, 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      logic [vdi_pkg::CFG_W-1:0] phase_words [10];
      vertex_type                v;
      logic                      fom;
      int                        p;
      int                        k;
      int                        f;

      phase_words = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd12, 4'd7, 4'd4};
      reset             = 1'b1;
      start             = 1'b0;
      req_first_of_mesh = 1'b0;
      {req_comp7, req_comp6, req_comp5, req_comp4,
       req_comp3, req_comp2, req_comp1, req_comp0} = '0;
      csr_valid         = 1'b0;
      csr_vertex_words  = '0;
      no_idle           = 1'b0;
      cur_words         = 8;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // zeros of both signs, NaN, infinities, extremes
      send_vertex(1'b1, {8{32'h0000_0000}});
      send_vertex(1'b0, {8{32'h8000_0000}});
      send_vertex(1'b0, {8{32'hFFFF_FFFF}});
      send_vertex(1'b0, {8{32'hFFFF_FFFF}});
      send_vertex(1'b0, {8{32'h7F80_0000}});
      send_vertex(1'b0, {8{32'h7F80_0000}});
      send_vertex(1'b0, {8{32'hFF80_0000}});
      send_vertex(1'b0, {4{32'h7F7F_FFFF, 32'h0000_0001}});
      send_vertex(1'b0, {32'h8000_0000, {7{32'h0000_0000}}});
      send_vertex(1'b0, {32'h3F80_0000, {7{32'h0000_0000}}});
      send_vertex(1'b0, {8{32'h7F80_0001}});
      // narrower compare against entries stored at full width
      drain();
      write_words(4'd1);
      send_vertex(1'b0, {{7{32'hDEAD_BEEF}}, 32'h8000_0000});
      send_vertex(1'b0, {{7{32'h0000_0000}}, 32'h7FC0_0000});
      drain();
      write_words(4'd0);
      send_vertex(1'b0, {{7{32'h1234_5678}}, 32'h7F80_0000});
      drain();
      write_words(4'd15);
      send_vertex(1'b0, {8{32'hFF80_0000}});
      send_vertex(1'b1, {8{32'hFFFF_FFFF}});
      send_vertex(1'b0, {4{32'h7F7F_FFFF, 32'h0000_0001}});

      for (p = 0; p < 10; p++) begin
         drain();
         write_words(phase_words[p]);
         for (k = 0; k < 58; k++) begin
            fom = mesh_history.size() == 0 || mesh_history.size() >= 40 ||
                  $urandom_range(0, 24) == 0;
            if (fom)
               mesh_history.delete();
            if (mesh_history.size() > 0 && $urandom_range(0, 99) < 45) begin
               // revisit a vertex: flip zero signs, scramble words not compared
               v = mesh_history[$urandom_range(0, mesh_history.size() - 1)];
               for (f = 0; f < 8; f++) begin
                  if (v[f][30:0] == 31'h0 && $urandom_range(0, 1) == 1)
                     v[f][31] = ~v[f][31];
                  if (f >= cur_words && $urandom_range(0, 1) == 1)
                     v[f] = $urandom;
               end
               if ($urandom_range(0, 7) == 0)
                  v[$urandom_range(0, cur_words - 1)] = pick_word();
            end else begin
               for (f = 0; f < 8; f++)
                  v[f] = pick_word();
            end
            mesh_history = {mesh_history, v};
            send_vertex(fom, v);
         end
      end

      // fill every entry, then overflow
      drain();
      write_words(4'd1);
      for (k = 0; k < vdi_pkg::MAX_UNIQUE; k++) begin
         for (f = 1; f < 8; f++)
            v[f] = $urandom;
         v[0] = k + 1;
         send_vertex(k == 0, v);
      end
      v[0] = 32'h4000_0000;
      send_vertex(1'b0, v);
      v[0] = 32'd5;
      send_vertex(1'b0, v);
      v[0] = 32'd1024;
      send_vertex(1'b0, v);
      v[0] = 32'h7FC0_0000;
      send_vertex(1'b0, v);
      v[0] = 32'h0000_0000;
      send_vertex(1'b0, v);
      v[0] = 32'h8000_0000;
      send_vertex(1'b0, v);
      send_vertex(1'b1, v);

      drain();
      if (mismatches == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
